FILE: rtl/core/tcce_pkg.sv
// shared types, constants and tables for the text console
`default_nettype none
package tcce_pkg;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int ESCAPE_LIMIT = 63;
  localparam int CELLS        = ROWS * COLUMNS;

  localparam int IDX_W  = 11;
  localparam int SW     = IDX_W + 1;
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int CNT_W  = 6;
  localparam int CELL_W = 16;

  localparam logic [SW-1:0] SW_MOVES = SW'(CELLS - COLUMNS);
  localparam logic [SW-1:0] SW_LAST  = SW'(CELLS - 1);
  localparam logic [SW-1:0] SW_COLS  = SW'(COLUMNS);
  localparam logic [SW-1:0] SW_CELLS = SW'(CELLS);

  localparam logic [IDX_W-1:0] IDX_COLS = IDX_W'(COLUMNS);
  localparam logic [COL_W-1:0] COL_END  = COL_W'(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_END  = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(ESCAPE_LIMIT);

  localparam logic [7:0] KEY_NEWLINE = 8'd10;
  localparam logic [7:0] KEY_RETURN  = 8'd13;
  localparam logic [7:0] KEY_ESCAPE  = 8'd27;
  localparam logic [7:0] KEY_BACK    = 8'd8;
  localparam logic [7:0] KEY_DELETE  = 8'd127;
  localparam logic [7:0] KEY_M       = 8'd109;
  localparam logic [7:0] KEY_ZERO    = 8'd48;
  localparam logic [7:0] KEY_ONE     = 8'd49;

  localparam logic [15:0] ATTR_RESET = 16'h0700;
  localparam logic [15:0] ATTR_BOLD  = 16'h0800;
  localparam logic [15:0] MASK_FG    = 16'hF8FF;
  localparam logic [15:0] MASK_BG    = 16'h0FFF;
  localparam logic [15:0] CHAR_SPACE = 16'h0020;

  localparam logic signed [12:0] FG_LO = 13'sd30;
  localparam logic signed [12:0] FG_HI = 13'sd37;
  localparam logic signed [12:0] BG_LO = 13'sd40;
  localparam logic signed [12:0] BG_HI = 13'sd47;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_ERASE = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } mem_req_t;

  function automatic logic [3:0] sgr_color(input logic [2:0] idx);
    logic [3:0] c;
    unique case (idx)
      3'd0: c = 4'h0;
      3'd1: c = 4'h4;
      3'd2: c = 4'h2;
      3'd3: c = 4'hE;
      3'd4: c = 4'h1;
      3'd5: c = 4'h5;
      3'd6: c = 4'h3;
      3'd7: c = 4'hF;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tcce_if.sv
// valid/ready channel interfaces for console commands and results
`default_nettype none
interface tcce_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [7:0]                char_code;
  logic                      force_req;
  logic                      erase_twice;
  logic [tcce_pkg::IDX_W-1:0] read_address;

  modport source (output valid, mode, char_code, force_req, erase_twice, read_address,
                  input ready);
  modport sink   (input valid, mode, char_code, force_req, erase_twice, read_address,
                  output ready);
endinterface

interface tcce_out_if;
  logic                      valid;
  logic                      ready;
  logic [tcce_pkg::IDX_W-1:0] cursor_position;
  logic [15:0]               attribute_now;
  logic                      escape_active;
  logic [15:0]               cell_data;

  modport source (output valid, cursor_position, attribute_now, escape_active, cell_data,
                  input ready);
  modport sink   (input valid, cursor_position, attribute_now, escape_active, cell_data,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tcce_cellbuf.sv
// screen cell buffer: one write port and one registered read port
`default_nettype none
module tcce_cellbuf (
  input  wire logic                      clk_i,
  input  wire tcce_pkg::mem_req_t        req_i,
  output      logic [tcce_pkg::CELL_W-1:0] rdata_o
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_o <= mem[req_i.rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/tcce_sgr.sv
// sgr color code decoder: new attribute from collected escape characters
`default_nettype none
module tcce_sgr (
  input  wire logic [7:0]  esc0_i,
  input  wire logic [7:0]  esc1_i,
  input  wire logic [7:0]  esc2_i,
  input  wire logic [15:0] attr_i,
  output      logic [15:0] attr_o
);
  import tcce_pkg::*;

  logic signed [12:0] d0;
  logic signed [12:0] d1;
  logic signed [12:0] code;
  logic signed [12:0] fg_off;
  logic signed [12:0] bg_off;

  assign d0     = $signed({5'd0, esc0_i}) - $signed({5'd0, KEY_ZERO});
  assign d1     = $signed({5'd0, esc1_i}) - $signed({5'd0, KEY_ZERO});
  assign code   = (d0 <<< 3) + (d0 <<< 1) + d1;
  assign fg_off = code - FG_LO;
  assign bg_off = code - BG_LO;

  always_comb begin
    attr_o = attr_i;
    if (esc1_i == KEY_M) begin
      if (esc0_i == KEY_ZERO) begin
        attr_o = ATTR_RESET;
      end else if (esc0_i == KEY_ONE) begin
        attr_o = attr_i | ATTR_BOLD;
      end
    end else if (esc2_i == KEY_M) begin
      if (code >= FG_LO && code <= FG_HI) begin
        attr_o = (attr_i & MASK_FG) | {4'h0, sgr_color(fg_off[2:0]), 8'h00};
      end else if (code >= BG_LO && code <= BG_HI) begin
        attr_o = (attr_i & MASK_BG) | {sgr_color(bg_off[2:0]), 12'h000};
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/text_console_with_color_escapes.sv
// text console top level: command sequencer, cursor, attribute and escape state
//
// in_i carries one command transaction: put character, erase backward, clear
// screen or read cell. out_o returns one result transaction per command with
// the cursor index, the attribute, the escape flag and the read cell word.
// Commands run one at a time on a single-write, single-read cell buffer;
// in_i.ready is high only while the sequencer idles.
// States from accept to result: put PUT, RESP, or PUT, MARK, RESP when it
// prints or feeds a line, with SCROLL and ZROW before MARK if it scrolls;
// erase ERASE, EMARK, RESP (ERASE, EMARK twice with erase_twice); read READ,
// RESP; clear CLEAR, MARK, RESP. A scroll moves one cell per cycle through the
// buffer read port, then zeroes the bottom row one cell per cycle. After reset
// the block sweeps the buffer once to zero it and draw the cursor cell; no
// command is taken meanwhile. A result is held in an output register; the next
// command is accepted while it waits, and a finished command waits in its result
// state until the receiver takes the previous result.
`default_nettype none
module text_console_with_color_escapes (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcce_in_if.sink   in_i,
  tcce_out_if.source out_o
);
  import tcce_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_PUT    = 10'b00_0000_0010,
    ST_SCROLL = 10'b00_0000_0100,
    ST_ZROW   = 10'b00_0000_1000,
    ST_MARK   = 10'b00_0001_0000,
    ST_ERASE  = 10'b00_0010_0000,
    ST_EMARK  = 10'b00_0100_0000,
    ST_CLEAR  = 10'b00_1000_0000,
    ST_READ   = 10'b01_0000_0000,
    ST_RESP   = 10'b10_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic              boot_q, boot_d;
  logic [SW-1:0]     sweep_q, sweep_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  wptr_q, wptr_d;
  logic [IDX_W-1:0]  cursor_q, cursor_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [15:0]       attr_q, attr_d;
  logic              esc_q, esc_d;
  logic [CNT_W-1:0]  ecount_q, ecount_d;
  logic [7:0]        echar_q [3];
  logic [7:0]        echar_d [3];
  logic [7:0]        echar_nx [3];
  mode_e             mode_q, mode_d;
  logic [7:0]        char_q, char_d;
  logic              force_q, force_d;
  logic              twice_q, twice_d;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic              addr_ok_q, addr_ok_d;

  logic              ovalid_q, ovalid_d;
  logic [IDX_W-1:0]  ocursor_q, ocursor_d;
  logic [15:0]       oattr_q, oattr_d;
  logic              oesc_q, oesc_d;
  logic [15:0]       odata_q, odata_d;

  mem_req_t          mreq;
  logic [CELL_W-1:0] rdata;
  logic [15:0]       sgr_attr;

  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic [IDX_W-1:0]  put_cur;
  logic              printable;
  logic              newline;

  tcce_cellbuf u_cellbuf (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  tcce_sgr u_sgr (
    .esc0_i (echar_nx[0]),
    .esc1_i (echar_nx[1]),
    .esc2_i (echar_nx[2]),
    .attr_i (attr_q),
    .attr_o (sgr_attr)
  );

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = ovalid_q;
  assign out_o.cursor_position = ocursor_q;
  assign out_o.attribute_now   = oattr_q;
  assign out_o.escape_active   = oesc_q;
  assign out_o.cell_data       = odata_q;

  // escape characters with the current byte stored at its position
  always_comb begin
    echar_nx = echar_q;
    if (ecount_q >= CNT_W'(2) && ecount_q <= CNT_W'(4)) begin
      echar_nx[2'(ecount_q - CNT_W'(2))] = char_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    boot_d    = boot_q;
    sweep_d   = sweep_q;
    pend_d    = pend_q;
    wptr_d    = wptr_q;
    cursor_d  = cursor_q;
    col_d     = col_q;
    row_d     = row_q;
    attr_d    = attr_q;
    esc_d     = esc_q;
    ecount_d  = ecount_q;
    echar_d   = echar_q;
    mode_d    = mode_q;
    char_d    = char_q;
    force_d   = force_q;
    twice_d   = twice_q;
    addr_d    = addr_q;
    addr_ok_d = addr_ok_q;
    ovalid_d  = ovalid_q & ~out_o.ready;
    ocursor_d = ocursor_q;
    oattr_d   = oattr_q;
    oesc_d    = oesc_q;
    odata_d   = odata_q;

    mreq.wr_en   = 1'b0;
    mreq.wr_addr = cursor_q;
    mreq.wr_data = '0;
    mreq.rd_en   = 1'b0;
    mreq.rd_addr = addr_q;

    printable = !(char_q == KEY_NEWLINE || char_q == KEY_RETURN || char_q == KEY_ESCAPE ||
                  char_q == KEY_BACK || char_q == KEY_DELETE);
    newline   = (char_q == KEY_NEWLINE);
    put_col   = col_q + COL_W'(printable);
    put_row   = row_q + ROW_W'(newline);
    put_cur   = cursor_q + IDX_W'(printable) + (newline ? IDX_COLS : '0);
    if (put_col == COL_END) begin
      put_col = '0;
      put_row = row_q + ROW_W'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mode_d    = mode_e'(in_i.mode);
          char_d    = in_i.char_code;
          force_d   = in_i.force_req;
          twice_d   = in_i.erase_twice;
          addr_d    = in_i.read_address;
          addr_ok_d = ({1'b0, in_i.read_address} < SW_CELLS);
          unique case (mode_e'(in_i.mode))
            MODE_PUT:   state_d = ST_PUT;
            MODE_ERASE: state_d = ST_ERASE;
            MODE_CLEAR: begin
              sweep_d = '0;
              state_d = ST_CLEAR;
            end
            MODE_READ:  state_d = ST_READ;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_PUT: begin
        state_d = ST_RESP;
        priority if (esc_q && !force_q) begin
          if (ecount_q < CNT_LIMIT) begin
            echar_d  = echar_nx;
            ecount_d = ecount_q + CNT_W'(1);
          end
          if (char_q == KEY_M) begin
            attr_d   = sgr_attr;
            ecount_d = '0;
            esc_d    = 1'b0;
          end
        end else if (char_q == KEY_RETURN) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_data = '0;
          cursor_d     = cursor_q - IDX_W'(col_q);
          col_d        = '0;
        end else if (char_q == KEY_ESCAPE && !esc_q) begin
          esc_d = 1'b1;
          if (ecount_q < CNT_LIMIT) begin
            ecount_d = ecount_q + CNT_W'(1);
          end
        end else if (char_q == KEY_BACK || char_q == KEY_DELETE) begin
          state_d = ST_RESP;
        end else begin
          if (printable) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_data = attr_q | {8'h00, char_q};
          end
          col_d    = put_col;
          row_d    = put_row;
          cursor_d = put_cur;
          state_d  = ST_MARK;
          if (put_row == ROW_END) begin
            row_d    = ROW_LAST;
            cursor_d = put_cur - IDX_COLS;
            sweep_d  = '0;
            pend_d   = 1'b0;
            state_d  = ST_SCROLL;
          end
        end
      end
      ST_SCROLL: begin
        if (pend_q) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = wptr_q;
          mreq.wr_data = rdata;
        end
        if (sweep_q < SW_MOVES) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = IDX_W'(sweep_q + SW_COLS);
          wptr_d       = sweep_q[IDX_W-1:0];
          pend_d       = 1'b1;
          sweep_d      = sweep_q + SW'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = ST_ZROW;
        end
      end
      ST_ZROW: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = sweep_q[IDX_W-1:0];
        mreq.wr_data = '0;
        sweep_d      = sweep_q + SW'(1);
        if (sweep_q == SW_LAST) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_data = attr_q | CHAR_SPACE;
        boot_d       = 1'b0;
        state_d      = boot_q ? ST_IDLE : ST_RESP;
      end
      ST_ERASE: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_data = '0;
        if (cursor_q != '0) begin
          cursor_d = cursor_q - IDX_W'(1);
          if (col_q == '0) begin
            col_d = COL_LAST;
            row_d = row_q - ROW_W'(1);
          end else begin
            col_d = col_q - COL_W'(1);
          end
        end
        state_d = ST_EMARK;
      end
      ST_EMARK: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_data = attr_q | CHAR_SPACE;
        if (twice_q) begin
          twice_d = 1'b0;
          state_d = ST_ERASE;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_CLEAR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = sweep_q[IDX_W-1:0];
        mreq.wr_data = '0;
        sweep_d      = sweep_q + SW'(1);
        if (sweep_q == SW_LAST) begin
          cursor_d = '0;
          col_d    = '0;
          row_d    = '0;
          state_d  = ST_MARK;
        end
      end
      ST_READ: begin
        mreq.rd_en   = addr_ok_q;
        mreq.rd_addr = addr_q;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d  = 1'b1;
          ocursor_d = cursor_q;
          oattr_d   = attr_q;
          oesc_d    = esc_q;
          odata_d   = (mode_q == MODE_READ && addr_ok_q) ? rdata : '0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      boot_q     <= 1'b1;
      sweep_q    <= '0;
      pend_q     <= 1'b0;
      cursor_q   <= '0;
      col_q      <= '0;
      row_q      <= '0;
      attr_q     <= ATTR_RESET;
      esc_q      <= 1'b0;
      ecount_q   <= '0;
      echar_q[0] <= '0;
      echar_q[1] <= '0;
      echar_q[2] <= '0;
      twice_q    <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      boot_q   <= boot_d;
      sweep_q  <= sweep_d;
      pend_q   <= pend_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      row_q    <= row_d;
      attr_q   <= attr_d;
      esc_q    <= esc_d;
      ecount_q <= ecount_d;
      echar_q  <= echar_d;
      twice_q  <= twice_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wptr_q    <= wptr_d;
    mode_q    <= mode_d;
    char_q    <= char_d;
    force_q   <= force_d;
    addr_q    <= addr_d;
    addr_ok_q <= addr_ok_d;
    ocursor_q <= ocursor_d;
    oattr_q   <= oattr_d;
    oesc_q    <= oesc_d;
    odata_q   <= odata_d;
  end

endmodule
`default_nettype wire
